@@ hdl/brt_pkg.sv @@
// Package for the bucketed record table: codes, record layout, default sizes.
// No dependencies; every other file in hdl/ imports it.
package brt_pkg;

	localparam int DEF_BUCKETS = 32;
	localparam int DEF_WAYS    = 16;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_UPDATE = 2'd1,
		OP_FIND   = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISS     = 2'd1,
		ST_EVICT    = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_MRD,
		S_MWT,
		S_SCAN,
		S_WREC,
		S_RDLAST,
		S_MOVE,
		S_FIN
	} state_t;

	// scan flavors: find the highest matching slot, pick a victim, recompute max rank
	typedef enum logic [1:0] {
		M_LOCATE,
		M_VICTIM,
		M_MAX
	} mode_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [31:0] rank;
		logic [31:0] data_loc;
		logic [31:0] meta_loc;
	} rec_t;

endpackage

@@ hdl/brt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on brt_pkg only by house convention.
module brt_ram
	import brt_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/brt_bucket_mod.sv @@
// Hash to bucket index: remainder by BUCKETS through a reciprocal multiply.
// Depends on brt_pkg.
module brt_bucket_mod
	import brt_pkg::*;
#(
	parameter int BUCKETS = DEF_BUCKETS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                hash,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	localparam int RW = $clog2(BUCKETS);
	localparam int SH = 32 + RW;
	// rounded-up reciprocal, exact quotient for every 32-bit hash
	localparam logic [63:0] MAGIC = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [16:0] M_LO  = MAGIC[16:0];
	localparam logic [15:0] M_HI  = MAGIC[32:17];

	logic [1:0]    step_q;
	logic [31:0]   h_q, q_q, qb;
	logic [48:0]   plo_q;
	logic [47:0]   phi_q;
	logic [65:0]   prod, quo;
	logic [RW-1:0] rem_q;

	assign prod = {1'b0, phi_q, 17'd0} + {17'd0, plo_q};
	assign quo  = prod >> SH;
	assign qb   = q_q * 32'(BUCKETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= 2'd1;
		end else if (step_q != 2'd0) begin
			step_q <= step_q + 2'd1;
		end
	end

	// step 1: partial products, step 2: quotient, step 3: remainder
	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= hash;
		end
		unique case (step_q)
			2'd1: begin
				plo_q <= 49'(h_q) * 49'(M_LO);
				phi_q <= 48'(h_q) * 48'(M_HI);
			end
			2'd2: q_q <= quo[31:0];
			2'd3: rem_q <= h_q[RW-1:0] - qb[RW-1:0];
			default: ;
		endcase
	end

	assign done   = (step_q == 2'd0);
	assign bucket = rem_q;

endmodule

@@ hdl/bucketed_record_table_with_eviction_top.sv @@
// Top level of the bucketed record table with max-rank eviction.
// Depends on brt_pkg, brt_bucket_mod and brt_ram.
//
// Usage: one command per transfer on the input channel (in_valid / in_stall),
// exactly one result per command on the output channel (out_valid / out_stall).
// Commands: add, update, find, delete on a 32-bit key hash; hash 0 is rejected
// with the reserved status and changes nothing.
// Records live in a one-port-read, one-port-write RAM of BUCKETS*WAYS entries;
// per-bucket fill count and max rank live in a second small RAM, with a valid
// bit per bucket so reset needs no clearing pass.
// Per command: bucket index (reciprocal multiply, three steps), bucket header
// read, then for all but add to a non-full bucket and the reserved hash a
// pipelined scan of the bucket at one slot per cycle; then record write(s) for
// commands that change the bucket, and for a hit update or delete and for add
// with eviction a second scan to recompute its max rank.
// One command is in flight at a time; the next one is taken once the result
// is loaded and the block is back in idle; the record RAM port sets the scan rate.
// in_stall is high whenever a command is in flight. A finished result sits in
// the output register; the next command is taken while it waits, and only the
// final handoff of that command waits on out_stall.
// Reset empties every bucket at once and clears the output channel.
module bucketed_record_table_with_eviction_top
	import brt_pkg::*;
#(
	parameter int BUCKETS         = DEF_BUCKETS,
	parameter int WAYS_PER_BUCKET = DEF_WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] key_hash,
	input  logic [31:0] evict_rank,
	input  logic [31:0] data_location,
	input  logic [31:0] meta_location,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] out_hash,
	output logic [31:0] out_rank,
	output logic [31:0] out_data_location,
	output logic [31:0] out_meta_location,
	output logic [31:0] bucket_max_rank
);

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int FILL_W = $clog2(WAYS_PER_BUCKET + 1);
	localparam int SLOT_W = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
	localparam int RECS   = BUCKETS * WAYS_PER_BUCKET;
	localparam int A_W    = $clog2(RECS);
	localparam int TOT_W  = $clog2(RECS + 1);
	localparam int META_W = FILL_W + 32;

	state_t state_q, state_nx;
	mode_t  mode_q;

	// command
	op_t  op_q;
	rec_t rec_q;

	// bucket index
	logic             mod_start;
	logic             mod_done;
	logic [BKT_W-1:0] bkt;

	// bucket header
	logic [BUCKETS-1:0] vld_q;
	logic               meta_re, meta_we;
	logic [META_W-1:0]  meta_rdata;
	logic [FILL_W-1:0]  fill_q, fill_new_q;
	logic [31:0]        top_q, top_new_q;
	logic [A_W-1:0]     base_q;
	logic               addnf_q;

	// record RAM
	logic           rec_we, rec_re;
	logic [A_W-1:0] rec_waddr, rec_raddr;
	logic [127:0]   rec_wdata, rec_rdata;
	rec_t           rdr;

	// scan
	logic [FILL_W-1:0] cnt_q, n_q, slot_full;
	logic [SLOT_W-1:0] slot_s1, pos_q;
	logic              v_s1, first_s1;
	logic              hit_q, hit_now, scan_end;
	rec_t              found_q;

	logic [TOT_W-1:0] total_q;

	// output
	logic    ovalid_q;
	status_t status_q;
	rec_t    out_q;
	logic [31:0] omax_q;
	logic    fin_go, modified;
	status_t fin_status;
	rec_t    fin_rec;
	logic [31:0] fin_top;

	assign in_stall = (state_q != S_IDLE);
	assign mod_start = (state_q == S_IDLE) && in_valid;
	assign rdr = rec_t'(rec_rdata);

	brt_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.hash   (key_hash),
		.done   (mod_done),
		.bucket (bkt)
	);

	brt_ram #(.WIDTH(META_W), .DEPTH(BUCKETS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (bkt),
		.wdata ({fill_new_q, fin_top}),
		.re    (meta_re),
		.raddr (bkt),
		.rdata (meta_rdata)
	);

	brt_ram #(.WIDTH(128), .DEPTH(RECS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	// scan order: locate runs top slot down, victim runs 0 then top down to 1
	always_comb begin
		unique case (mode_q)
			M_LOCATE: slot_full = fill_q - FILL_W'(1) - cnt_q;
			M_VICTIM: slot_full = (cnt_q == '0) ? '0 : FILL_W'(WAYS_PER_BUCKET) - cnt_q;
			default:  slot_full = cnt_q;
		endcase
	end

	assign hit_now  = (mode_q == M_LOCATE) && v_s1 && (rdr.hash == rec_q.hash);
	assign scan_end = (cnt_q == n_q) && !v_s1;

	// result assembly
	assign modified = (rec_q.hash != '0)
		&& ((op_q == OP_ADD) || (hit_q && (op_q != OP_FIND)));
	assign fin_top  = modified ? top_new_q : top_q;
	assign fin_go   = (state_q == S_FIN) && (!ovalid_q || !out_stall);

	always_comb begin
		fin_status = ST_OK;
		fin_rec    = '0;
		if (rec_q.hash == '0) begin
			fin_status = ST_RESERVED;
		end else if (op_q == OP_ADD) begin
			if (!addnf_q) begin
				fin_status = ST_EVICT;
				fin_rec    = found_q;
			end
		end else if (!hit_q) begin
			fin_status = ST_MISS;
		end else if (op_q != OP_UPDATE) begin
			fin_rec = found_q;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_nx = S_MOD;
			S_MOD:  if (mod_done) state_nx = S_MRD;
			S_MRD:  state_nx = S_MWT;
			S_MWT: begin
				if (rec_q.hash == '0) begin
					state_nx = S_FIN;
				end else if (op_q == OP_ADD && !(vld_q[bkt] && meta_rdata[META_W-1 -: FILL_W]
						== FILL_W'(WAYS_PER_BUCKET))) begin
					state_nx = S_WREC;
				end else begin
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				unique case (mode_q)
					M_LOCATE: begin
						if (hit_now) begin
							unique case (op_q)
								OP_FIND:   state_nx = S_FIN;
								OP_UPDATE: state_nx = S_WREC;
								default:   state_nx = S_RDLAST;
							endcase
						end else if (scan_end) begin
							state_nx = S_FIN;
						end
					end
					M_VICTIM: if (scan_end) state_nx = S_WREC;
					default:  if (scan_end) state_nx = S_FIN;
				endcase
			end
			S_WREC:   state_nx = addnf_q ? S_FIN : S_SCAN;
			S_RDLAST: state_nx = S_MOVE;
			S_MOVE:   state_nx = S_SCAN;
			S_FIN:    if (fin_go) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		meta_re   = 1'b0;
		meta_we   = 1'b0;
		rec_re    = 1'b0;
		rec_we    = 1'b0;
		rec_raddr = base_q + A_W'(slot_full[SLOT_W-1:0]);
		rec_waddr = base_q + A_W'(pos_q);
		rec_wdata = rec_q;
		unique case (state_q)
			S_MRD: meta_re = 1'b1;
			S_SCAN: rec_re = (cnt_q < n_q);
			S_RDLAST: begin
				rec_re    = 1'b1;
				rec_raddr = base_q + A_W'(fill_q - FILL_W'(1));
			end
			S_WREC: begin
				rec_we = 1'b1;
				if (addnf_q) begin
					rec_waddr = base_q + A_W'(fill_q);
				end
			end
			S_MOVE: begin
				rec_we    = 1'b1;
				rec_wdata = rec_rdata;
			end
			S_FIN: meta_we = fin_go;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			vld_q    <= '0;
			ovalid_q <= 1'b0;
			total_q  <= '0;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_SCAN) begin
				v_s1 <= rec_re;
				if (rec_re) begin
					cnt_q <= cnt_q + FILL_W'(1);
				end
			end else begin
				v_s1  <= 1'b0;
				cnt_q <= '0;
			end
			if (fin_go) begin
				vld_q[bkt] <= 1'b1;
				ovalid_q   <= 1'b1;
				if (modified && op_q == OP_ADD && addnf_q) begin
					total_q <= total_q + TOT_W'(1);
				end else if (modified && op_q == OP_DELETE) begin
					total_q <= total_q - TOT_W'(1);
				end
			end else if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mod_start) begin
			op_q  <= op_t'(operation);
			rec_q <= '{key_hash, evict_rank, data_location, meta_location};
		end
		if (state_q == S_SCAN) begin
			slot_s1  <= slot_full[SLOT_W-1:0];
			first_s1 <= (cnt_q == '0);
		end
		unique case (state_q)
			S_MWT: begin
				fill_q     <= vld_q[bkt] ? meta_rdata[META_W-1 -: FILL_W] : '0;
				fill_new_q <= vld_q[bkt] ? meta_rdata[META_W-1 -: FILL_W] : '0;
				top_q      <= vld_q[bkt] ? meta_rdata[31:0] : '0;
				base_q     <= A_W'(bkt) * A_W'(WAYS_PER_BUCKET);
				hit_q      <= 1'b0;
				addnf_q    <= (op_q == OP_ADD) && !(vld_q[bkt]
					&& meta_rdata[META_W-1 -: FILL_W] == FILL_W'(WAYS_PER_BUCKET));
				mode_q     <= (op_q == OP_ADD) ? M_VICTIM : M_LOCATE;
				n_q        <= (op_q == OP_ADD) ? FILL_W'(WAYS_PER_BUCKET)
					: (vld_q[bkt] ? meta_rdata[META_W-1 -: FILL_W] : '0);
			end
			S_SCAN: begin
				if (v_s1) begin
					unique case (mode_q)
						M_LOCATE: begin
							if (hit_now) begin
								hit_q   <= 1'b1;
								pos_q   <= slot_s1;
								found_q <= rdr;
							end
						end
						M_VICTIM: begin
							if (first_s1 || rdr.rank > found_q.rank) begin
								pos_q   <= slot_s1;
								found_q <= rdr;
							end
						end
						default: begin
							if (rdr.rank > top_new_q) begin
								top_new_q <= rdr.rank;
							end
						end
					endcase
				end
			end
			S_WREC: begin
				if (addnf_q) begin
					fill_new_q <= fill_q + FILL_W'(1);
					top_new_q  <= (rec_q.rank > top_q) ? rec_q.rank : top_q;
				end else begin
					top_new_q <= '0;
				end
				mode_q <= M_MAX;
				n_q    <= fill_new_q;
			end
			S_MOVE: begin
				fill_new_q <= fill_q - FILL_W'(1);
				n_q        <= fill_q - FILL_W'(1);
				top_new_q  <= '0;
				mode_q     <= M_MAX;
			end
			default: ;
		endcase
		if (fin_go) begin
			status_q <= fin_status;
			out_q    <= fin_rec;
			omax_q   <= fin_top;
		end
	end

	assign out_valid         = ovalid_q;
	assign status            = status_q;
	assign out_hash          = out_q.hash;
	assign out_rank          = out_q.rank;
	assign out_data_location = out_q.data_loc;
	assign out_meta_location = out_q.meta_loc;
	assign bucket_max_rank   = omax_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the bucketed record table: random and directed add/update/find/delete
// traffic with a behavioral table predictor in a scoreboard class.
// Depends on brt_pkg and bucketed_record_table_with_eviction_top.
module tb_top;
	import brt_pkg::*;

	localparam int NB = DEF_BUCKETS;
	localparam int NW = DEF_WAYS;
	localparam int WATCHDOG = 20000;

	// expected result of one command
	typedef struct {
		status_t     st;
		logic [31:0] hash, rank, dloc, mloc, top;
	} answer_t;

	// table predictor plus queue of pending answers
	class table_scoreboard;
		rec_t        rows [NB][NW];
		int          fill [NB];
		logic [31:0] top_rank [NB];
		int          total;
		answer_t     pending [$];
		int          errors;

		function new();
			foreach (fill[b]) begin
				fill[b] = 0;
				top_rank[b] = 0;
			end
			total = 0;
			errors = 0;
		endfunction

		// note an accepted command: update the table and queue its answer
		function void note_command(op_t op, rec_t r);
			answer_t a;
			int b, pos, victim;
			logic [31:0] m;
			b = r.hash % NB;
			a.st = ST_OK;
			a.hash = 0; a.rank = 0; a.dloc = 0; a.mloc = 0;
			if (r.hash == 0) begin
				a.st = ST_RESERVED;
			end else if (op == OP_ADD) begin
				if (fill[b] < NW) begin
					rows[b][fill[b]] = r;
					fill[b]++;
					total++;
				end else begin
					victim = 0;
					for (int i = NW - 1; i > 0; i--)
						if (rows[b][i].rank > rows[b][victim].rank) victim = i;
					{a.hash, a.rank, a.dloc, a.mloc} = rows[b][victim];
					rows[b][victim] = r;
					a.st = ST_EVICT;
				end
			end else begin
				// highest matching slot wins
				pos = -1;
				for (int i = fill[b] - 1; i >= 0; i--)
					if (pos < 0 && rows[b][i].hash == r.hash) pos = i;
				if (pos < 0) begin
					a.st = ST_MISS;
				end else if (op == OP_UPDATE) begin
					rows[b][pos] = r;
				end else if (op == OP_FIND) begin
					{a.hash, a.rank, a.dloc, a.mloc} = rows[b][pos];
				end else begin
					{a.hash, a.rank, a.dloc, a.mloc} = rows[b][pos];
					rows[b][pos] = rows[b][fill[b] - 1];
					fill[b]--;
					total--;
				end
			end
			m = 0;
			for (int i = 0; i < fill[b]; i++)
				if (rows[b][i].rank > m) m = rows[b][i].rank;
			top_rank[b] = m;
			a.top = m;
			pending.push_back(a);
		endfunction

		function void check_result(answer_t got);
			answer_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status %0d", $time, got.st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.st !== e.st) begin
				$display("%0t: status exp %0d got %0d", $time, e.st, got.st);
				errors++;
			end
			if (got.hash !== e.hash) begin
				$display("%0t: out_hash exp %h got %h", $time, e.hash, got.hash);
				errors++;
			end
			if (got.rank !== e.rank) begin
				$display("%0t: out_rank exp %h got %h", $time, e.rank, got.rank);
				errors++;
			end
			if (got.dloc !== e.dloc) begin
				$display("%0t: out_data_location exp %h got %h", $time, e.dloc, got.dloc);
				errors++;
			end
			if (got.mloc !== e.mloc) begin
				$display("%0t: out_meta_location exp %h got %h", $time, e.mloc, got.mloc);
				errors++;
			end
			if (got.top !== e.top) begin
				$display("%0t: bucket_max_rank exp %h got %h", $time, e.top, got.top);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [1:0]  operation, status;
	logic [31:0] key_hash, evict_rank, data_location, meta_location;
	logic [31:0] out_hash, out_rank, out_data_location, out_meta_location, bucket_max_rank;

	table_scoreboard sb;
	int idle_cycles;
	bit stim_done;
	int cmd_count, op_hist [4];

	// keys recently added, so updates/finds/deletes can hit
	logic [31:0] live_keys [$];

	bucketed_record_table_with_eviction_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .key_hash(key_hash), .evict_rank(evict_rank),
		.data_location(data_location), .meta_location(meta_location),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_hash(out_hash), .out_rank(out_rank),
		.out_data_location(out_data_location), .out_meta_location(out_meta_location),
		.bucket_max_rank(bucket_max_rank)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one, sometimes none for a while
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// drive one command and hold it until the transfer; valid stays up for a
	// back-to-back command, drops only when a gap follows
	task automatic send_command(op_t op, logic [31:0] h, logic [31:0] rk,
		logic [31:0] dl, logic [31:0] ml);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		key_hash      <= h;
		evict_rank    <= rk;
		data_location <= dl;
		meta_location <= ml;
		do @(posedge clk); while (in_stall);
		// transfer happened on this edge
		sb.note_command(op, '{hash: h, rank: rk, data_loc: dl, meta_loc: ml});
		cmd_count++;
		op_hist[op]++;
		if (op == OP_ADD && h != 0) live_keys.push_back(h);
		if (live_keys.size() > 64) void'(live_keys.pop_front());
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// key in a narrow set of buckets so buckets fill up and evict
	function automatic logic [31:0] rand_key();
		logic [31:0] k;
		case ($urandom_range(0, 9))
			0: k = $urandom();
			1: k = 32'd0;
			default: k = ($urandom() & ~32'(NB - 1)) | 32'($urandom_range(0, 3));
		endcase
		if (live_keys.size() > 0 && $urandom_range(0, 2) == 0)
			k = live_keys[$urandom_range(0, live_keys.size() - 1)];
		return k;
	endfunction

	// result side: random stall with an occasional long one, check on each transfer
	initial begin
		answer_t got;
		int hold;
		hold = 0;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.st = status_t'(status);
				got.hash = out_hash; got.rank = out_rank;
				got.dloc = out_data_location; got.mloc = out_meta_location;
				got.top = bucket_max_rank;
				sb.check_result(got);
			end
			if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 199) == 0) begin
				hold = $urandom_range(20, 80);
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 8) out_stall <= 1'b1;
			else if ($urandom_range(0, 99) < 70) out_stall <= 1'b0;
		end
	end

	// watchdog: cycles without any transfer
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else if (!stim_done || sb.pending.size() > 0) idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: timeout, %0d results outstanding", $time, sb.pending.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] k;
		sb = new();
		stim_done = 0;
		cmd_count = 0;
		op_hist = '{0, 0, 0, 0};
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		operation     <= OP_ADD;
		key_hash      <= 0;
		evict_rank    <= 0;
		data_location <= 0;
		meta_location <= 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reserved key on every op, misses on an empty table
		send_command(OP_ADD, 32'd0, 32'hFFFF_FFFF, 32'h1, 32'h2);
		send_command(OP_UPDATE, 32'd0, 32'd5, 32'd6, 32'd7);
		send_command(OP_FIND, 32'd0, 0, 0, 0);
		send_command(OP_DELETE, 32'd0, 0, 0, 0);
		send_command(OP_FIND, 32'hFFFF_FFFF, 0, 0, 0);
		send_command(OP_DELETE, 32'h0000_0021, 0, 0, 0);
		send_command(OP_UPDATE, 32'h0000_0021, 1, 1, 1);
		// fill bucket 1 past full: eviction of highest rank, ties keep slot 0, else the highest slot
		for (int i = 0; i < NW + 2; i++)
			send_command(OP_ADD, 32'(i * NB + 1), (i == 3 || i == 9) ? 32'hFFFF_FFFF : 32'(i),
				~32'(i), 32'hFFFF_FFFF);
		// duplicate key, then update/find/delete hit the highest copy
		send_command(OP_ADD, 32'hFFFF_FFFF, 32'd0, 32'hA, 32'hB);
		send_command(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hC, 32'hD);
		send_command(OP_UPDATE, 32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFFF, 32'd0);
		send_command(OP_FIND, 32'hFFFF_FFFF, 0, 0, 0);
		send_command(OP_DELETE, 32'hFFFF_FFFF, 0, 0, 0);
		send_command(OP_DELETE, 32'hFFFF_FFFF, 0, 0, 0);

		// random: uniform mix of ops on few buckets so buckets fill, evict and drain
		for (int n = 0; n < 1400; n++) begin
			k = rand_key();
			send_command(op_t'($urandom_range(0, 3)), k, rand_word(), rand_word(), rand_word());
		end
		in_valid <= 1'b0;
		stim_done = 1;

		while (sb.pending.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Ran %0d commands (add %0d, update %0d, find %0d, delete %0d), %0d records left",
			cmd_count, op_hist[0], op_hist[1], op_hist[2], op_hist[3], sb.total);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ bucketed_record_table_with_eviction_top.f @@
hdl/brt_pkg.sv
hdl/brt_ram.sv
hdl/brt_bucket_mod.sv
hdl/bucketed_record_table_with_eviction_top.sv
verif/tb_top.sv
